// ===== rtl/core/lz4sd_pkg.sv =====
// ----------------------------------------------------------------------------
// lz4sd_pkg
// Shared types, constants and helpers of the LZ4 stream decompressor.
// ----------------------------------------------------------------------------
package lz4sd_pkg;

    // History ring geometry
    localparam int HIST_DEPTH = 65536;
    localparam int HIST_AW    = $clog2(HIST_DEPTH);

    // Offset arithmetic is done one bit wider than a 16-bit offset
    localparam int                 OFF_W          = 17;
    localparam logic [OFF_W-1:0]   HIST_DEPTH_EXT = OFF_W'(HIST_DEPTH);

    // Stream format constants
    localparam logic [31:0] LEGACY_MAGIC   = 32'h184c2102;
    localparam logic [30:0] BLOCK_SIZE_MAX = 31'h7fffffff;
    localparam logic [3:0]  NIBBLE_EXT     = 4'hf;
    localparam logic [7:0]  BYTE_EXT       = 8'hff;
    localparam logic [31:0] MATCH_MIN      = 32'd4;
    localparam logic [31:0] MATCH_EXT_BASE = 32'd19;
    localparam logic [3:0]  SIZE_BYTES     = 4'd4;

    // Output buffer
    localparam int OBUF_DEPTH = 3;
    localparam int OBUF_PW    = $clog2(OBUF_DEPTH);
    localparam int OBUF_CW    = $clog2(OBUF_DEPTH + 1);

    // APB register file
    localparam int   APB_AW          = 3;
    localparam int   APB_DW          = 32;
    localparam logic REG_HEADER_SKIP = 1'b0;
    localparam logic REG_LEGACY_MODE = 1'b1;

    typedef enum logic [1:0] {
        CMD_DATA  = 2'd0,
        CMD_PULL  = 2'd1,
        CMD_START = 2'd2,
        CMD_NONE  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_END        = 2'd1,
        ST_BAD_OFFSET = 2'd2,
        ST_REFUSED    = 2'd3
    } status_t;

    typedef enum logic [10:0] {
        PH_HDR    = 11'b000_0000_0001,
        PH_SIZE   = 11'b000_0000_0010,
        PH_RAW    = 11'b000_0000_0100,
        PH_TOKEN  = 11'b000_0000_1000,
        PH_LITEXT = 11'b000_0001_0000,
        PH_LIT    = 11'b000_0010_0000,
        PH_OFF0   = 11'b000_0100_0000,
        PH_OFF1   = 11'b000_1000_0000,
        PH_MLEXT  = 11'b001_0000_0000,
        PH_SKIP   = 11'b010_0000_0000,
        PH_END    = 11'b100_0000_0000
    } phase_t;

    typedef struct packed {
        logic        out_valid;
        logic [7:0]  out_byte;
        logic        copy_pending;
        status_t     status;
        logic [31:0] byte_total;
    } result_t;

    // Saturating add of a byte to a 32-bit length
    function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [7:0] b);
        logic [32:0] s;
        s = {1'b0, a} + 33'(b);
        return s[32] ? 32'hffff_ffff : s[31:0];
    endfunction

endpackage

// ===== rtl/core/lz4sd_in_if.sv =====
// ----------------------------------------------------------------------------
// lz4sd_in_if
// Input channel: command and compressed byte with valid/ready handshake.
// ----------------------------------------------------------------------------
interface lz4sd_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] cmd;
    logic [7:0] data_byte;

    modport source (output valid, output cmd, output data_byte, input ready);
    modport sink (input valid, input cmd, input data_byte, output ready);
endinterface

// ===== rtl/core/lz4sd_out_if.sv =====
// ----------------------------------------------------------------------------
// lz4sd_out_if
// Output channel: one result per input transaction, valid/ready handshake.
// ----------------------------------------------------------------------------
interface lz4sd_out_if;
    logic        valid;
    logic        ready;
    logic        out_valid;
    logic [7:0]  out_byte;
    logic        copy_pending;
    logic [1:0]  status;
    logic [31:0] byte_total;

    modport source (output valid, output out_valid, output out_byte,
                    output copy_pending, output status, output byte_total,
                    input ready);
    modport sink (input valid, input out_valid, input out_byte,
                  input copy_pending, input status, input byte_total,
                  output ready);
endinterface

// ===== rtl/core/lz4_stream_decompressor.sv =====
// A result passes the byte stage, then the output buffer. Throughput: one transaction
// per cycle while the output buffer has room, set by the single history RAM read and
// write per item; a byte still being written is forwarded to the next read.
// Reset (rst_n, async, active low) clears parser, pointers, counters, pipeline
// and output buffer; the history RAM is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
// lz4_stream_decompressor
// Streaming LZ4 block decoder with a 64 KiB history ring and pull-driven copy.
// ----------------------------------------------------------------------------
module lz4_stream_decompressor
    import lz4sd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    lz4sd_in_if.sink          in_ch,
    lz4sd_out_if.source       out_ch
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [3:0] header_skip_reg;
    logic       legacy_mode_reg;
    logic       cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_skip_reg <= '0;
            legacy_mode_reg <= 1'b0;
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == REG_HEADER_SKIP)
            begin
                header_skip_reg <= pwdata[3:0];
            end
            else
            begin
                legacy_mode_reg <= pwdata[0];
            end
        end
    end

    assign prdata = (paddr[2] == REG_LEGACY_MODE) ? APB_DW'(legacy_mode_reg)
                                                   : APB_DW'(header_skip_reg);

    // ------------------------------------------------------------------
    // Parser state
    // ------------------------------------------------------------------
    phase_t              phase_reg,        phase_next;
    logic [3:0]          skip_left_reg,    skip_left_next;
    logic [31:0]         acc_reg,          acc_next;
    logic [30:0]         block_left_reg,   block_left_next;
    logic [3:0]          match_nib_reg,    match_nib_next;
    logic [31:0]         lit_left_reg,     lit_left_next;
    logic [15:0]         match_offset_reg, match_offset_next;
    logic [31:0]         match_left_reg,   match_left_next;
    logic [HIST_AW-1:0]  wp_reg,           wp_next;
    logic [31:0]         produced_reg,     produced_next;

    logic                in_fire;
    cmd_t                cmd;
    logic                hdr_done;
    phase_t              cur_phase;
    logic [3:0]          cur_skip;
    logic [31:0]         cur_acc;
    logic [31:0]         size_word;
    logic [3:0]          skip_inc;
    logic [30:0]         block_dec;
    logic [31:0]         lit_dec;
    logic [31:0]         lit_sum;
    logic [31:0]         acc_sum;
    logic [15:0]         offset_new;
    logic                offset_bad;
    logic [HIST_AW-1:0]  wp_inc;
    logic [31:0]         produced_inc;
    logic [OFF_W-1:0]    rd_diff;
    logic [HIST_AW-1:0]  rd_addr;

    logic                emit_lit;
    logic                pull_go;
    logic                do_step;
    phase_t              step_to;
    status_t             item_status;
    status_t             result_status;

    assign cmd     = cmd_t'(in_ch.cmd);
    assign in_fire = in_ch.valid && in_ch.ready;

    // Header bytes used up: this byte already belongs to the first size word
    assign hdr_done  = (phase_reg == PH_HDR) && (skip_left_reg >= header_skip_reg);
    assign cur_phase = hdr_done ? PH_SIZE : phase_reg;
    assign cur_skip  = hdr_done ? 4'd0 : skip_left_reg;
    assign cur_acc   = hdr_done ? 32'd0 : acc_reg;

    assign size_word = cur_acc | (32'(in_ch.data_byte) << {cur_skip[1:0], 3'b000});
    assign skip_inc  = cur_skip + 4'd1;

    assign block_dec  = (block_left_reg != '0) ? block_left_reg - 31'd1 : '0;
    assign lit_dec    = (lit_left_reg != '0) ? lit_left_reg - 32'd1 : '0;
    assign lit_sum    = sat_add32(lit_left_reg, in_ch.data_byte);
    assign acc_sum    = sat_add32(cur_acc, in_ch.data_byte);
    assign offset_new = {in_ch.data_byte, match_offset_reg[7:0]};
    assign offset_bad = (offset_new == '0) || (32'(offset_new) > produced_reg) ||
                        (OFF_W'(offset_new) > HIST_DEPTH_EXT);

    assign wp_inc       = (wp_reg == HIST_AW'(HIST_DEPTH - 1)) ? '0 : wp_reg + 1'b1;
    assign produced_inc = (produced_reg == 32'hffff_ffff) ? produced_reg
                                                          : produced_reg + 32'd1;

    // Copy source: write pointer minus offset, modulo ring depth
    assign rd_diff = OFF_W'(wp_reg) - OFF_W'(match_offset_reg);
    assign rd_addr = rd_diff[OFF_W-1] ? HIST_AW'(rd_diff + HIST_DEPTH_EXT)
                                      : HIST_AW'(rd_diff);

    // Decode one transaction and compute the next parser state
    always_comb
    begin
        phase_next        = phase_reg;
        skip_left_next    = skip_left_reg;
        acc_next          = acc_reg;
        block_left_next   = block_left_reg;
        match_nib_next    = match_nib_reg;
        lit_left_next     = lit_left_reg;
        match_offset_next = match_offset_reg;
        match_left_next   = match_left_reg;
        wp_next           = wp_reg;
        produced_next     = produced_reg;
        emit_lit          = 1'b0;
        pull_go           = 1'b0;
        do_step           = 1'b0;
        step_to           = phase_reg;
        item_status       = ST_OK;

        if (in_fire)
        begin
            unique case (cmd)
                CMD_START:
                begin
                    phase_next        = PH_HDR;
                    skip_left_next    = '0;
                    acc_next          = '0;
                    block_left_next   = '0;
                    match_nib_next    = '0;
                    lit_left_next     = '0;
                    match_offset_next = '0;
                    match_left_next   = '0;
                    wp_next           = '0;
                    produced_next     = '0;
                end
                CMD_PULL:
                begin
                    if (match_left_reg != '0)
                    begin
                        pull_go         = 1'b1;
                        match_left_next = match_left_reg - 32'd1;
                    end
                end
                CMD_DATA:
                begin
                    if (match_left_reg != '0)
                    begin
                        item_status = ST_REFUSED;
                    end
                    else
                    begin
                        unique case (cur_phase)
                            PH_HDR:
                            begin
                                skip_left_next = skip_left_reg + 4'd1;
                            end
                            PH_SIZE:
                            begin
                                phase_next = PH_SIZE;
                                if (skip_inc >= SIZE_BYTES)
                                begin
                                    skip_left_next = '0;
                                    acc_next       = '0;
                                    if (legacy_mode_reg)
                                    begin
                                        // Skip magic words; clamp oversized chunks
                                        if (size_word != LEGACY_MAGIC)
                                        begin
                                            block_left_next = size_word[31] ? BLOCK_SIZE_MAX
                                                                            : size_word[30:0];
                                            if (size_word != '0)
                                            begin
                                                phase_next = PH_TOKEN;
                                            end
                                        end
                                    end
                                    else if (size_word == '0)
                                    begin
                                        phase_next = PH_END;
                                    end
                                    else
                                    begin
                                        block_left_next = size_word[30:0];
                                        if (size_word[30:0] != '0)
                                        begin
                                            phase_next = size_word[31] ? PH_RAW : PH_TOKEN;
                                        end
                                    end
                                end
                                else
                                begin
                                    skip_left_next = skip_inc;
                                    acc_next       = size_word;
                                end
                            end
                            PH_RAW:
                            begin
                                emit_lit = 1'b1;
                                do_step  = 1'b1;
                                step_to  = PH_RAW;
                            end
                            PH_TOKEN:
                            begin
                                lit_left_next  = 32'(in_ch.data_byte[7:4]);
                                match_nib_next = in_ch.data_byte[3:0];
                                do_step        = 1'b1;
                                if (in_ch.data_byte[7:4] == NIBBLE_EXT)
                                begin
                                    step_to = PH_LITEXT;
                                end
                                else if (in_ch.data_byte[7:4] != '0)
                                begin
                                    step_to = PH_LIT;
                                end
                                else
                                begin
                                    step_to = PH_OFF0;
                                end
                            end
                            PH_LITEXT:
                            begin
                                lit_left_next = lit_sum;
                                do_step       = 1'b1;
                                step_to       = (in_ch.data_byte == BYTE_EXT) ? PH_LITEXT
                                                                              : PH_LIT;
                            end
                            PH_LIT:
                            begin
                                emit_lit      = 1'b1;
                                lit_left_next = lit_dec;
                                do_step       = 1'b1;
                                step_to       = (lit_dec != '0) ? PH_LIT : PH_OFF0;
                            end
                            PH_OFF0:
                            begin
                                match_offset_next = 16'(in_ch.data_byte);
                                do_step           = 1'b1;
                                step_to           = PH_OFF1;
                            end
                            PH_OFF1:
                            begin
                                match_offset_next = offset_new;
                                do_step           = 1'b1;
                                if (offset_bad)
                                begin
                                    // Drop the match and skip the rest of the block
                                    item_status = ST_BAD_OFFSET;
                                    step_to     = PH_SKIP;
                                end
                                else if (match_nib_reg == NIBBLE_EXT)
                                begin
                                    acc_next = MATCH_EXT_BASE;
                                    if (block_left_reg == 31'd1)
                                    begin
                                        match_left_next = MATCH_EXT_BASE;
                                        acc_next        = '0;
                                    end
                                    step_to = PH_MLEXT;
                                end
                                else
                                begin
                                    match_left_next = 32'(match_nib_reg) + MATCH_MIN;
                                    step_to         = PH_TOKEN;
                                end
                            end
                            PH_MLEXT:
                            begin
                                acc_next = acc_sum;
                                if ((in_ch.data_byte != BYTE_EXT) ||
                                    (block_left_reg <= 31'd1))
                                begin
                                    match_left_next = acc_sum;
                                    acc_next        = '0;
                                end
                                do_step = 1'b1;
                                step_to = (in_ch.data_byte == BYTE_EXT) ? PH_MLEXT : PH_TOKEN;
                            end
                            PH_SKIP:
                            begin
                                do_step = 1'b1;
                                step_to = PH_SKIP;
                            end
                            PH_END:
                            begin
                                phase_next = PH_END;
                            end
                            default:
                            begin
                                phase_next = phase_reg;
                            end
                        endcase
                    end
                end
                CMD_NONE:
                begin
                    phase_next = phase_reg;
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase

            // Consume one block byte; fall back to size parsing at block end
            if (do_step)
            begin
                block_left_next = block_dec;
                phase_next      = (block_dec == '0) ? PH_SIZE : step_to;
            end

            // Advance ring pointer and byte count for every produced byte
            if (emit_lit || pull_go)
            begin
                wp_next       = wp_inc;
                produced_next = produced_inc;
            end
        end
    end

    assign result_status = ((item_status == ST_OK) && (phase_next == PH_END)) ? ST_END
                                                                             : item_status;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_HDR;
            skip_left_reg    <= '0;
            acc_reg          <= '0;
            block_left_reg   <= '0;
            match_nib_reg    <= '0;
            lit_left_reg     <= '0;
            match_offset_reg <= '0;
            match_left_reg   <= '0;
            wp_reg           <= '0;
            produced_reg     <= '0;
        end
        else
        begin
            phase_reg        <= phase_next;
            skip_left_reg    <= skip_left_next;
            acc_reg          <= acc_next;
            block_left_reg   <= block_left_next;
            match_nib_reg    <= match_nib_next;
            lit_left_reg     <= lit_left_next;
            match_offset_reg <= match_offset_next;
            match_left_reg   <= match_left_next;
            wp_reg           <= wp_next;
            produced_reg     <= produced_next;
        end
    end

    // ------------------------------------------------------------------
    // Byte stage: history read data arrives, byte is written back
    // ------------------------------------------------------------------
    logic               s1_valid_reg;
    result_t            s1_res_reg;
    logic               s1_from_ram_reg;
    logic               s1_fwd_reg;
    logic [7:0]         s1_fwd_byte_reg;
    logic [HIST_AW-1:0] s1_waddr_reg;
    logic [7:0]         s1_byte;
    logic [7:0]         ram_rdata;
    logic               ram_we;
    logic               fwd_hit;
    result_t            s1_result;

    // Pick the produced byte: literal, RAM data, or the byte written last cycle
    always_comb
    begin
        if (!s1_res_reg.out_valid)
        begin
            s1_byte = '0;
        end
        else if (!s1_from_ram_reg)
        begin
            s1_byte = s1_res_reg.out_byte;
        end
        else if (s1_fwd_reg)
        begin
            s1_byte = s1_fwd_byte_reg;
        end
        else
        begin
            s1_byte = ram_rdata;
        end
    end

    assign ram_we  = s1_valid_reg && s1_res_reg.out_valid;
    assign fwd_hit = ram_we && (s1_waddr_reg == rd_addr);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= in_fire;
        end
    end

    // Capture the transaction result; the byte is filled in during the byte stage that follows
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_res_reg.out_valid    <= emit_lit || pull_go;
            s1_res_reg.out_byte     <= emit_lit ? in_ch.data_byte : 8'd0;
            s1_res_reg.copy_pending <= (match_left_next != '0);
            s1_res_reg.status       <= result_status;
            s1_res_reg.byte_total   <= produced_next;
            s1_from_ram_reg         <= pull_go;
            s1_fwd_reg              <= pull_go && fwd_hit;
            s1_fwd_byte_reg         <= s1_byte;
            s1_waddr_reg            <= wp_reg;
        end
    end

    lz4sd_ram #(
        .WIDTH (8),
        .DEPTH (HIST_DEPTH)
    ) u_hist_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (s1_waddr_reg),
        .wdata (s1_byte),
        .re    (pull_go),
        .raddr (rd_addr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        s1_result          = s1_res_reg;
        s1_result.out_byte = s1_byte;
    end

    // ------------------------------------------------------------------
    // Output buffer
    // ------------------------------------------------------------------
    result_t              obuf_reg [OBUF_DEPTH];
    logic [OBUF_PW-1:0]   obuf_wr_reg, obuf_wr_next;
    logic [OBUF_PW-1:0]   obuf_rd_reg, obuf_rd_next;
    logic [OBUF_CW-1:0]   obuf_count_reg, obuf_count_next;
    logic                 obuf_push;
    logic                 obuf_pop;
    result_t              obuf_head;

    assign obuf_push = s1_valid_reg;
    assign obuf_pop  = out_ch.valid && out_ch.ready;

    always_comb
    begin
        obuf_wr_next    = obuf_wr_reg;
        obuf_rd_next    = obuf_rd_reg;
        obuf_count_next = obuf_count_reg;
        if (obuf_push)
        begin
            obuf_wr_next = (obuf_wr_reg == OBUF_PW'(OBUF_DEPTH - 1)) ? '0
                                                                      : obuf_wr_reg + 1'b1;
        end
        if (obuf_pop)
        begin
            obuf_rd_next = (obuf_rd_reg == OBUF_PW'(OBUF_DEPTH - 1)) ? '0
                                                                      : obuf_rd_reg + 1'b1;
        end
        case ({obuf_push, obuf_pop})
            2'b10:   obuf_count_next = obuf_count_reg + 1'b1;
            2'b01:   obuf_count_next = obuf_count_reg - 1'b1;
            default: obuf_count_next = obuf_count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            obuf_wr_reg    <= '0;
            obuf_rd_reg    <= '0;
            obuf_count_reg <= '0;
        end
        else
        begin
            obuf_wr_reg    <= obuf_wr_next;
            obuf_rd_reg    <= obuf_rd_next;
            obuf_count_reg <= obuf_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (obuf_push)
        begin
            obuf_reg[obuf_wr_reg] <= s1_result;
        end
    end

    // Take a new transaction only if the buffer can hold it and the one in flight
    assign in_ch.ready = ((OBUF_CW + 1)'(obuf_count_reg) + (OBUF_CW + 1)'(s1_valid_reg))
                         < (OBUF_CW + 1)'(OBUF_DEPTH);

    assign obuf_head           = obuf_reg[obuf_rd_reg];
    assign out_ch.valid        = (obuf_count_reg != '0);
    assign out_ch.out_valid    = obuf_head.out_valid;
    assign out_ch.out_byte     = obuf_head.out_byte;
    assign out_ch.copy_pending = obuf_head.copy_pending;
    assign out_ch.status       = obuf_head.status;
    assign out_ch.byte_total   = obuf_head.byte_total;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
`ifndef SYNTHESIS
    a_obuf_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (obuf_push && !obuf_pop) |-> (obuf_count_reg != OBUF_CW'(OBUF_DEPTH)))
        else $error("output buffer overflow");

    a_fwd_only_on_copy: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s1_fwd_reg) |-> (s1_from_ram_reg && s1_res_reg.out_valid))
        else $error("forwarded byte on a transaction without a copy read");

    a_pull_fills_stage: assert property (@(posedge clk) disable iff (!rst_n)
        pull_go |=> (s1_valid_reg && s1_from_ram_reg && s1_res_reg.out_valid))
        else $error("copy read without a byte stage entry");

    a_wp_tracks_count: assert property (@(posedge clk) disable iff (!rst_n)
        (produced_reg == '0) |-> (wp_reg == '0))
        else $error("write pointer moved without produced bytes");
`endif

endmodule

// ===== rtl/core/lz4sd_ram.sv =====
// ----------------------------------------------------------------------------
// lz4sd_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module lz4sd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
